### hw/rtl/flst_pkg.sv
// shared types, constants and helper functions of the factored logistic trainer
// depends on nothing; imported by the interfaces, the map, sigmoid and top level, and the testbench

package flst_pkg;

  localparam int IDX_W   = 14;
  localparam int VAL_W   = 17;
  localparam int PRED_W  = 17;
  localparam int DELTA_W = 18;
  localparam int MODEL_W = 32;
  localparam int ACC_W   = 48;
  localparam int CFG_W   = 25;
  localparam int CFG_IDX_W = 1;

  localparam int NUM_WEIGHTS_DEF = 1024;
  localparam int BATCH_DEPTH_DEF = 1024;
  localparam int GROUP_SIZE_DEF  = 12;
  localparam int NUM_FACTORS_DEF = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L2_DECAY      = 1'd1;

  localparam logic [CFG_W-1:0]   LR_RESET     = 25'd16777;
  localparam logic [CFG_W-1:0]   L2_RESET     = 25'd0;
  localparam logic [MODEL_W-1:0] WEIGHT_INIT  = 32'hFFFD_70A4;  // -167772
  localparam logic [MODEL_W-1:0] FACTOR_INIT  = 32'h0100_0000;  // 1.0
  localparam logic [VAL_W-1:0]   VAL_ONE      = 17'd65536;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_MAP,
    ST_S1, ST_S2, ST_S3, ST_F1, ST_F2,
    ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6, ST_U7, ST_U8, ST_U9,
    ST_B1, ST_B2
  } state_t;

  // factor code per position inside a group, zero means unselected
  function automatic logic [1:0] pos_factor(input logic [5:0] pos);
    logic [1:0] code;
    case (pos)
      6'd0:    code = 2'd1;
      6'd1:    code = 2'd2;
      6'd10:   code = 2'd3;
      default: code = 2'd0;
    endcase
    return code;
  endfunction

  // sigmoid samples at 0, 0.25, ..., 8 in q0.16
  function automatic logic [PRED_W-1:0] sig_tab(input logic [5:0] k);
    logic [PRED_W-1:0] s;
    case (k)
      6'd0:  s = 17'd32768; 6'd1:  s = 17'd36843; 6'd2:  s = 17'd40793;
      6'd3:  s = 17'd44511; 6'd4:  s = 17'd47911; 6'd5:  s = 17'd50941;
      6'd6:  s = 17'd53581; 6'd7:  s = 17'd55834; 6'd8:  s = 17'd57724;
      6'd9:  s = 17'd59287; 6'd10: s = 17'd60565; 6'd11: s = 17'd61598;
      6'd12: s = 17'd62428; 6'd13: s = 17'd63090; 6'd14: s = 17'd63615;
      6'd15: s = 17'd64030; 6'd16: s = 17'd64357; 6'd17: s = 17'd64614;
      6'd18: s = 17'd64816; 6'd19: s = 17'd64974; 6'd20: s = 17'd65097;
      6'd21: s = 17'd65194; 6'd22: s = 17'd65269; 6'd23: s = 17'd65328;
      6'd24: s = 17'd65374; 6'd25: s = 17'd65410; 6'd26: s = 17'd65438;
      6'd27: s = 17'd65459; 6'd28: s = 17'd65476; 6'd29: s = 17'd65489;
      6'd30: s = 17'd65500; 6'd31: s = 17'd65508; 6'd32: s = 17'd65514;
      default: s = 17'd65514;
    endcase
    return s;
  endfunction

  function automatic logic [MODEL_W-1:0] sat32(input logic signed [39:0] x);
    logic [MODEL_W-1:0] r;
    if (x[39:31] == 9'h000 || x[39:31] == 9'h1FF) begin
      r = x[31:0];
    end else if (x[39]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [ACC_W-1:0] sat48(input logic signed [48:0] x);
    logic [ACC_W-1:0] r;
    if (x[48] == x[47]) begin
      r = x[47:0];
    end else if (x[48]) begin
      r = {1'b1, 47'd0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

endpackage

### hw/rtl/flst_if.sv
// valid/ready channel interfaces for feature beats and result beats
// depends on flst_pkg for field widths

interface flst_feat_if
  import flst_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [IDX_W-1:0]   feat_index;
  logic [VAL_W-1:0]   feat_value;
  logic               label;
  logic               last_feature;

  modport source (output valid, op, feat_index, feat_value, label, last_feature,
                  input ready);
  modport sink   (input valid, op, feat_index, feat_value, label, last_feature,
                  output ready);
endinterface

interface flst_res_if
  import flst_pkg::*;
  #(parameter int SLOT_W = 10)
  ();
  logic                      valid;
  logic                      ready;
  logic [PRED_W-1:0]         prediction;
  logic signed [DELTA_W-1:0] error_delta;
  logic [SLOT_W-1:0]         batch_slot;

  modport source (output valid, prediction, error_delta, batch_slot, input ready);
  modport sink   (input valid, prediction, error_delta, batch_slot, output ready);
endinterface

### hw/rtl/flst_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing

module flst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/flst_map.sv
// feature index to weight slot and factor mapping
// depends on flst_pkg; division by the group size is a reciprocal multiply

module flst_map
  import flst_pkg::*;
#(
  parameter int NUM_WEIGHTS = NUM_WEIGHTS_DEF,
  parameter int GROUP_SIZE  = GROUP_SIZE_DEF,
  parameter int NUM_FACTORS = NUM_FACTORS_DEF
) (
  input  logic [IDX_W-1:0]                 feat_index,
  output logic                             sel,
  output logic [$clog2(NUM_WEIGHTS)-1:0]   wslot,
  output logic [((NUM_FACTORS > 1) ? $clog2(NUM_FACTORS) : 1)-1:0] fidx
);

  localparam int WW = $clog2(NUM_WEIGHTS);
  localparam int FW = (NUM_FACTORS > 1) ? $clog2(NUM_FACTORS) : 1;
  localparam int GW = $clog2(GROUP_SIZE);
  localparam int SH = IDX_W + GW;
  localparam int MW = SH + 1;
  localparam longint RECIP = ((64'd1 << SH) + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam logic [MW-1:0] MUL = MW'(RECIP);

  logic [IDX_W-1:0]    x;
  logic [IDX_W+MW-1:0] prod;
  logic [IDX_W-1:0]    q;
  logic [IDX_W-1:0]    qg;
  logic [IDX_W-1:0]    pos;
  logic [1:0]          code;
  logic [7:0]          code_m1;

  always_comb begin
    x       = feat_index - IDX_W'(1);
    prod    = {{MW{1'b0}}, x} * {{IDX_W{1'b0}}, MUL};
    q       = prod[SH +: IDX_W];
    qg      = IDX_W'(q * GROUP_SIZE);
    pos     = x - qg;
    code    = pos_factor(pos[5:0]);
    code_m1 = {6'd0, code} - 8'd1;
    sel     = (feat_index != '0) && (32'(q) < NUM_WEIGHTS) && (code != 2'd0) &&
              (32'(code_m1) < NUM_FACTORS);
    wslot   = WW'(q);
    fidx    = FW'(code_m1);
  end

endmodule

### hw/rtl/flst_sigmoid.sv
// piecewise linear sigmoid over [-8, 8) with saturation, signed q24.24 in, q0.16 out
// depends on flst_pkg for the sample table

module flst_sigmoid
  import flst_pkg::*;
(
  input  logic signed [48:0] score,
  output logic [PRED_W-1:0]  prediction
);

  localparam logic signed [48:0] POS8 = 49'sd134217728;
  localparam logic signed [48:0] NEG8 = -49'sd134217728;

  logic [48:0]       mag;
  logic [5:0]        k;
  logic [21:0]       frac;
  logic [PRED_W-1:0] lo;
  logic [PRED_W-1:0] diff;
  logic [38:0]       step;
  logic [PRED_W-1:0] val;

  always_comb begin
    mag  = score[48] ? 49'(-score) : score;
    k    = mag[27:22];
    frac = mag[21:0];
    lo   = sig_tab(k);
    diff = sig_tab(k + 6'd1) - lo;
    step = 39'(diff) * 39'(frac);
    if (k[5]) begin
      val = sig_tab(6'd32);
    end else begin
      val = lo + PRED_W'(step >> 22);
    end
    if (score >= POS8) begin
      prediction = VAL_ONE;
    end else if (score < NEG8) begin
      prediction = '0;
    end else if (score[48]) begin
      prediction = VAL_ONE - val;
    end else begin
      prediction = val;
    end
  end

endmodule

### hw/rtl/factored_logistic_sgd_trainer_top.sv
// factored logistic regression trainer: one feature beat at a time, weights in ram
// sequence: a score beat passes map, then the score states if selected; after a last score
// beat the result is formed and held until the output register frees; an update beat
// passes map, then the update states if selected, and the bias update on the last beat
// flow: the serial multiply sequencer takes a new feature beat only when back in idle
// reset: sync, active high; a clearing pass loads every weight before the first beat is
// taken (config writes are taken during it)

module factored_logistic_sgd_trainer_top
  import flst_pkg::*;
#(
  parameter int NUM_WEIGHTS = NUM_WEIGHTS_DEF,
  parameter int BATCH_DEPTH = BATCH_DEPTH_DEF,
  parameter int GROUP_SIZE  = GROUP_SIZE_DEF,
  parameter int NUM_FACTORS = NUM_FACTORS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  flst_feat_if.sink            feature,
  flst_res_if.source           result
);

  localparam int WW = $clog2(NUM_WEIGHTS);
  localparam int BW = $clog2(BATCH_DEPTH);
  localparam int FW = (NUM_FACTORS > 1) ? $clog2(NUM_FACTORS) : 1;
  localparam logic [WW-1:0] LAST_W = WW'(NUM_WEIGHTS - 1);
  localparam logic [BW-1:0] LAST_B = BW'(BATCH_DEPTH - 1);

  state_t state, state_next;

  // config registers
  logic [CFG_W-1:0] lr;
  logic [CFG_W-1:0] l2;

  // captured beat
  logic             op_r;
  logic [IDX_W-1:0] idx_r;
  logic [VAL_W-1:0] v_r;
  logic             label_r;
  logic             last_r;

  // mapping
  logic          map_sel;
  logic [WW-1:0] map_ws;
  logic [FW-1:0] map_fi;
  logic          sel_r;
  logic [WW-1:0] ws_r;
  logic [FW-1:0] fi_r;

  // model state outside the ram
  logic [MODEL_W-1:0] factor [NUM_FACTORS];
  logic [MODEL_W-1:0] bias;
  logic [ACC_W-1:0]   acc;
  logic [BW-1:0]      write_slot;
  logic [BW-1:0]      read_slot;
  logic [WW-1:0]      clr_addr;

  // datapath registers
  logic signed [63:0] p_a;
  logic signed [57:0] p_b;
  logic signed [43:0] p_d;
  logic signed [27:0] d_reg;
  logic signed [57:0] p_l;
  logic signed [59:0] p_m;
  logic signed [53:0] p_n;
  logic [MODEL_W-1:0] w_hold;
  logic signed [48:0] s_sum;

  // ram ports
  logic               w_we;
  logic [WW-1:0]      w_waddr;
  logic [MODEL_W-1:0] w_wdata;
  logic [MODEL_W-1:0] w_rd;
  logic               r_we;
  logic [DELTA_W-1:0] ring_rd;

  // output register
  logic                      out_valid;
  logic [PRED_W-1:0]         out_pred;
  logic signed [DELTA_W-1:0] out_delta;
  logic [BW-1:0]             out_slot;

  // combinational helpers
  logic [MODEL_W-1:0]        f_cur;
  logic signed [48:0]        acc_sum;
  logic signed [39:0]        w_sum;
  logic signed [39:0]        f_sum;
  logic signed [39:0]        b_sum;
  logic [MODEL_W-1:0]        w_new;
  logic [PRED_W-1:0]         pred_c;
  logic signed [DELTA_W-1:0] delta_c;
  logic                      out_free;
  logic                      take;

  flst_map #(
    .NUM_WEIGHTS(NUM_WEIGHTS),
    .GROUP_SIZE (GROUP_SIZE),
    .NUM_FACTORS(NUM_FACTORS)
  ) u_map (
    .feat_index(idx_r),
    .sel       (map_sel),
    .wslot     (map_ws),
    .fidx      (map_fi)
  );

  flst_sigmoid u_sig (
    .score     (s_sum),
    .prediction(pred_c)
  );

  // weight store; the read address follows the captured index so data is ready after map
  flst_ram #(.WIDTH(MODEL_W), .DEPTH(NUM_WEIGHTS)) u_weight_ram (
    .clk  (clk),
    .we   (w_we),
    .waddr(w_waddr),
    .wdata(w_wdata),
    .raddr(map_ws),
    .rdata(w_rd)
  );

  // delta ring; always reading the replay slot
  flst_ram #(.WIDTH(DELTA_W), .DEPTH(BATCH_DEPTH)) u_ring_ram (
    .clk  (clk),
    .we   (r_we),
    .waddr(write_slot),
    .wdata(delta_c),
    .raddr(read_slot),
    .rdata(ring_rd)
  );

  assign result.valid       = out_valid;
  assign result.prediction  = out_pred;
  assign result.error_delta = out_delta;
  assign result.batch_slot  = out_slot;

  always_comb begin
    f_cur    = factor[fi_r];
    acc_sum  = $signed(acc) + $signed(p_b[57:16]);
    w_sum    = $signed(w_hold) + $signed(p_n[53:16]) - $signed(p_l[57:24]);
    f_sum    = $signed(f_cur) + $signed(p_n[53:16]) - $signed(p_l[57:24]);
    b_sum    = $signed(bias) + $signed(d_reg) - $signed(p_l[57:24]);
    w_new    = sat32(w_sum);
    delta_c  = (label_r ? 18'sd65536 : 18'sd0) - $signed({1'b0, pred_c});
    out_free = !out_valid || result.ready;
    take     = feature.valid && feature.ready;
  end

  // weight write port: clearing sweep or the update of the current slot
  always_comb begin
    w_we    = 1'b0;
    w_waddr = ws_r;
    w_wdata = w_new;
    if (state == ST_CLEAR) begin
      w_we    = 1'b1;
      w_waddr = clr_addr;
      w_wdata = WEIGHT_INIT;
    end else if (state == ST_U5) begin
      w_we = 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    feature.ready = 1'b0;
    r_we          = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_W) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        feature.ready = 1'b1;
        if (feature.valid) begin
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        if (op_r) begin
          state_next = ST_U1;
        end else if (map_sel) begin
          state_next = ST_S1;
        end else if (last_r) begin
          state_next = ST_F1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_S1: state_next = ST_S2;
      ST_S2: state_next = ST_S3;
      ST_S3: state_next = last_r ? ST_F1 : ST_IDLE;
      ST_F1: state_next = ST_F2;
      ST_F2: begin
        // hold the finished result until the output register frees
        if (out_free) begin
          r_we       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_U1: state_next = ST_U2;
      ST_U2: begin
        if (sel_r) begin
          state_next = ST_U3;
        end else if (last_r) begin
          state_next = ST_B1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_U3: state_next = ST_U4;
      ST_U4: state_next = ST_U5;
      ST_U5: state_next = ST_U6;
      ST_U6: state_next = ST_U7;
      ST_U7: state_next = ST_U8;
      ST_U8: state_next = ST_U9;
      ST_U9: state_next = last_r ? ST_B1 : ST_IDLE;
      ST_B1: state_next = ST_B2;
      ST_B2: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lr         <= LR_RESET;
      l2         <= L2_RESET;
      bias       <= '0;
      acc        <= '0;
      write_slot <= '0;
      read_slot  <= '0;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NUM_FACTORS; i++) begin
        factor[i] <= FACTOR_INIT;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEARNING_RATE: lr <= cfg_wdata;
          REG_L2_DECAY:      l2 <= cfg_wdata;
          default: ;
        endcase
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + WW'(1);
      end
      // drained beat leaves unless a new result loads in the same cycle
      if (result.ready && !(state == ST_F2 && out_free)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_S3: acc <= sat48(acc_sum);
        ST_F2: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            acc        <= '0;
            write_slot <= (write_slot == LAST_B) ? '0 : write_slot + BW'(1);
          end
        end
        ST_U9: factor[fi_r] <= sat32(f_sum);
        ST_B2: begin
          bias      <= sat32(b_sum);
          read_slot <= (read_slot == LAST_B) ? '0 : read_slot + BW'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      op_r    <= feature.op;
      idx_r   <= feature.feat_index;
      v_r     <= (feature.feat_value > VAL_ONE) ? VAL_ONE : feature.feat_value;
      label_r <= feature.label;
      last_r  <= feature.last_feature;
    end
    if (state == ST_F2 && out_free) begin
      out_pred  <= pred_c;
      out_delta <= delta_c;
      out_slot  <= write_slot;
    end
    case (state)
      ST_MAP: begin
        sel_r <= map_sel;
        ws_r  <= map_ws;
        fi_r  <= map_fi;
      end
      // score: weight * factor, then * value
      ST_S1: p_a <= $signed(w_rd) * $signed(f_cur);
      ST_S2: p_b <= $signed(p_a[63:24]) * $signed({1'b0, v_r});
      ST_F1: s_sum <= $signed(acc) + $signed(bias);
      // update: scaled delta, then weight with the old factor
      ST_U1: begin
        p_d    <= $signed(ring_rd) * $signed({1'b0, lr});
        w_hold <= w_rd;
      end
      ST_U2: begin
        d_reg <= p_d[43:16];
        p_l   <= $signed({1'b0, l2}) * $signed(w_hold);
      end
      ST_U3: p_m <= $signed(d_reg) * $signed(f_cur);
      ST_U4: p_n <= $signed(p_m[59:24]) * $signed({1'b0, v_r});
      ST_U5: w_hold <= w_new;
      // factor with the new weight
      ST_U6: p_l <= $signed({1'b0, l2}) * $signed(f_cur);
      ST_U7: p_m <= $signed(d_reg) * $signed(w_hold);
      ST_U8: p_n <= $signed(p_m[59:24]) * $signed({1'b0, v_r});
      ST_B1: p_l <= $signed({1'b0, l2}) * $signed(bias);
      default: ;
    endcase
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the factored logistic trainer: feature beats in, result beats out
// depends on flst_pkg, the flst_feat_if / flst_res_if interfaces and the trainer top level

module testbench;
  import flst_pkg::*;

  typedef struct {
    logic             op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic             label;
    logic             last;
  } feat_beat_t;

  typedef struct {
    logic [PRED_W-1:0]         pred;
    logic signed [DELTA_W-1:0] delta;
    logic [9:0]                slot;
  } score_result_t;

  localparam logic OP_SCORE  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LEARNING_RATE;
  logic [CFG_W-1:0] cfg_wdata = '0;

  flst_feat_if feat ();
  flst_res_if #(.SLOT_W(10)) res ();

  factored_logistic_sgd_trainer_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .feature(feat.sink), .result(res.source)
  );

  always #1 clk = ~clk;

  // stimulus and expectation stores
  feat_beat_t    pending_beats[$];
  score_result_t expected_scores[$];
  int            mismatches = 0;
  bit            calm = 1'b0;   // no idling on either side while set

  // append one beat to the tail of the pending queue
  function automatic void enqueue_beat(feat_beat_t b);
    pending_beats = {pending_beats, b};
  endfunction

  // shadow model state
  int     shadow_w[1024];
  int     shadow_f[3];
  int     shadow_bias;
  longint shadow_acc;
  int     shadow_ring[1024];
  int     wr_slot, rd_slot;
  longint shadow_lr, shadow_l2;

  // sigmoid samples at 0, 0.25 .. 8 in q0.16
  localparam int SIG_PTS[33] = '{
    32768, 36843, 40793, 44511, 47911, 50941, 53581, 55834,
    57724, 59287, 60565, 61598, 62428, 63090, 63615, 64030,
    64357, 64614, 64816, 64974, 65097, 65194, 65269, 65328,
    65374, 65410, 65438, 65459, 65476, 65489, 65500, 65508, 65514};

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint clamp48(longint x);
    longint hi;
    hi = (64'sd1 <<< 47) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic int sigmoid_q16(longint s);
    longint a;
    int k, v;
    if (s >= 8 * 64'sd16777216) return 65536;
    if (s < -8 * 64'sd16777216) return 0;
    a = s < 0 ? -s : s;
    k = int'(a >>> 22);
    if (k >= 32) v = SIG_PTS[32];
    else v = SIG_PTS[k] + int'(((SIG_PTS[k+1] - SIG_PTS[k]) * (a & 64'h3FFFFF)) >>> 22);
    return s < 0 ? 65536 - v : v;
  endfunction

  function automatic void reset_shadow();
    foreach (shadow_w[i]) shadow_w[i] = -167772;
    foreach (shadow_f[i]) shadow_f[i] = 16777216;
    foreach (shadow_ring[i]) shadow_ring[i] = 0;
    shadow_bias = 0;
    shadow_acc = 0;
    wr_slot = 0;
    rd_slot = 0;
    shadow_lr = 16777;
    shadow_l2 = 0;
  endfunction

  // apply one accepted beat to the shadow model, queue a result when one is due
  function automatic void train_step(feat_beat_t b);
    longint v, wf, d, w, f, bb;
    int pos, wslot, fi, pred, dl;
    bit sel;
    score_result_t r;
    v = (b.val > 65536) ? 65536 : b.val;
    sel = 0;
    wslot = 0;
    fi = 0;
    if (b.idx != 0) begin
      pos = (int'(b.idx) - 1) % 12;
      wslot = (int'(b.idx) - 1) / 12;
      case (pos)
        0: fi = 1;
        1: fi = 2;
        10: fi = 3;
        default: fi = 0;
      endcase
      sel = (fi != 0) && (wslot < 1024);
      fi = fi - 1;
    end
    if (b.op == OP_SCORE) begin
      if (sel) begin
        wf = (longint'(shadow_w[wslot]) * shadow_f[fi]) >>> 24;
        shadow_acc = clamp48(shadow_acc + ((wf * v) >>> 16));
      end
      if (b.last) begin
        pred = sigmoid_q16(shadow_acc + shadow_bias);
        dl = (b.label ? 65536 : 0) - pred;
        shadow_ring[wr_slot] = dl;
        r.pred = PRED_W'(pred);
        r.delta = DELTA_W'(dl);
        r.slot = 10'(wr_slot);
        expected_scores = {expected_scores, r};
        wr_slot = (wr_slot + 1) % 1024;
        shadow_acc = 0;
      end
    end else begin
      d = (longint'(shadow_ring[rd_slot]) * shadow_lr) >>> 16;
      if (sel) begin
        w = shadow_w[wslot];
        f = shadow_f[fi];
        // weight moves with the old factor, factor with the new weight
        w = clamp32(w + ((((d * f) >>> 24) * v) >>> 16) - ((shadow_l2 * w) >>> 24));
        shadow_w[wslot] = int'(w);
        f = clamp32(f + ((((d * w) >>> 24) * v) >>> 16) - ((shadow_l2 * f) >>> 24));
        shadow_f[fi] = int'(f);
      end
      if (b.last) begin
        bb = shadow_bias;
        shadow_bias = int'(clamp32(bb + d - ((shadow_l2 * bb) >>> 24)));
        rd_slot = (rd_slot + 1) % 1024;
      end
    end
  endfunction

  // driver: feature beats from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      feat.valid <= 1'b0;
    end else begin
      if (feat.valid && feat.ready) begin
        train_step('{feat.op, feat.feat_index, feat.feat_value, feat.label, feat.last_feature});
      end
      if (!feat.valid || feat.ready) begin
        if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
          feat_beat_t b;
          b = pending_beats.pop_front();
          feat.op <= b.op;
          feat.feat_index <= b.idx;
          feat.feat_value <= b.val;
          feat.label <= b.label;
          feat.last_feature <= b.last;
          feat.valid <= 1'b1;
        end else begin
          feat.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result beats against the oldest expectation, with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_scores.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat pred=%0d", res.prediction);
        end else begin
          score_result_t e;
          e = expected_scores.pop_front();
          if (res.prediction !== e.pred || res.error_delta !== e.delta ||
              res.batch_slot !== e.slot) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected pred=%0d delta=%0d slot=%0d, got %0d %0d %0d",
                       e.pred, e.delta, e.slot,
                       res.prediction, res.error_delta, res.batch_slot);
          end
        end
      end
      res.ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  initial begin
    feat.valid = 1'b0;
    feat.op = OP_SCORE;
    feat.feat_index = '0;
    feat.feat_value = '0;
    feat.label = 1'b0;
    feat.last_feature = 1'b0;
    res.ready = 1'b0;
  end

  // watchdog
  initial begin
    #4000000;
    $display("testbench: errors");
    $finish;
  end

  // generator bookkeeping: deltas stored but not yet replayed, and replay copies
  int         unreplayed = 0;
  feat_beat_t replay_beats[$];
  int         replay_lens[$];

  task automatic write_reg(logic [CFG_IDX_W-1:0] which, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    if (which == REG_LEARNING_RATE) shadow_lr = value;
    else shadow_l2 = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] rand_index();
    int slot, sel;
    case ($urandom_range(9))
      7: return IDX_W'($urandom_range(12288, 1));
      8: return IDX_W'($urandom_range(16383, 12289));
      9: return '0;
      default: begin
        slot = $urandom_range(1023);
        sel = $urandom_range(2);
        return IDX_W'(slot * 12 + (sel == 2 ? 10 : sel) + 1);
      end
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      8: return $urandom_range(1) ? 17'd65536 : 17'd0;
      9: return VAL_W'($urandom_range(131071, 65537));   // oversized, clipped to one
      default: return VAL_W'($urandom_range(65536));
    endcase
  endfunction

  function automatic void add_score_sample(int n);
    feat_beat_t b;
    logic lbl;
    lbl = 1'($urandom_range(1));
    for (int i = 0; i < n; i++) begin
      b = '{OP_SCORE, rand_index(), rand_value(), lbl, i == n - 1};
      enqueue_beat(b);
      b.op = OP_UPDATE;
      replay_beats = {replay_beats, b};
    end
    replay_lens = {replay_lens, n};
    unreplayed++;
  endfunction

  function automatic void add_replay_sample();
    int n;
    n = replay_lens.pop_front();
    for (int i = 0; i < n; i++) enqueue_beat(replay_beats.pop_front());
    unreplayed--;
  endfunction

  task automatic wait_drained();
    while (pending_beats.size() > 0 || feat.valid || expected_scores.size() > 0)
      @(posedge clk);
    // trailing update beats make no result, give them time to finish
    repeat (40) @(posedge clk);
  endtask

  logic [CFG_W-1:0] lr_set[5] = '{25'd16777, 25'h1FFFFFF, 25'd0, 25'd262144, 25'd16777};
  logic [CFG_W-1:0] l2_set[5] = '{25'd0, 25'd0, 25'h1FFFFFF, 25'd4096, 25'd16777216};

  initial begin
    int added, r;
    reset_shadow();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // register writes are taken during the clearing pass
    write_reg(REG_LEARNING_RATE, 25'd16777);
    write_reg(REG_L2_DECAY, 25'd0);

    // directed: field extremes, unselected positions, out-of-range slot, ignored last beat
    enqueue_beat('{OP_SCORE, 14'd1, 17'd0, 1'b1, 1'b0});
    enqueue_beat('{OP_SCORE, 14'd2, 17'd65536, 1'b1, 1'b0});
    enqueue_beat('{OP_SCORE, 14'd11, 17'h1FFFF, 1'b1, 1'b0});
    enqueue_beat('{OP_SCORE, 14'd0, 17'd40000, 1'b1, 1'b0});
    enqueue_beat('{OP_SCORE, 14'd3, 17'd65536, 1'b1, 1'b0});
    enqueue_beat('{OP_SCORE, 14'd12277, 17'd65536, 1'b1, 1'b0});
    enqueue_beat('{OP_SCORE, 14'd12289, 17'd65536, 1'b1, 1'b0});
    enqueue_beat('{OP_SCORE, 14'h3FFF, 17'd65536, 1'b1, 1'b1});
    enqueue_beat('{OP_SCORE, 14'd12288, 17'd1234, 1'b0, 1'b1});
    enqueue_beat('{OP_UPDATE, 14'd1, 17'd65536, 1'b0, 1'b0});
    enqueue_beat('{OP_UPDATE, 14'd2, 17'h1FFFF, 1'b0, 1'b0});
    enqueue_beat('{OP_UPDATE, 14'd12277, 17'd30000, 1'b0, 1'b1});
    enqueue_beat('{OP_UPDATE, 14'd11, 17'd65536, 1'b1, 1'b0});
    enqueue_beat('{OP_UPDATE, 14'h3FFF, 17'd65536, 1'b1, 1'b1});
    enqueue_beat('{OP_SCORE, 14'd11, 17'd65535, 1'b0, 1'b1});
    unreplayed = 1;
    wait_drained();

    // random phases, one register setting each, the sender holding off between them
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_LEARNING_RATE, lr_set[ph]);
      write_reg(REG_L2_DECAY, l2_set[ph]);
      calm = (ph == 1);
      added = 0;
      while (added < 400) begin
        r = $urandom_range(9);
        added += 3;
        if (r < 5 || unreplayed == 0) begin
          add_score_sample($urandom_range(6, 1));
        end else if (r < 8 && replay_lens.size() > 0) begin
          add_replay_sample();
        end else if (r == 9) begin
          // lone score beat with random last mark
          enqueue_beat('{OP_SCORE, rand_index(), rand_value(),
                         1'($urandom_range(1)), 1'($urandom_range(1))});
          if (pending_beats[$].last) unreplayed++;
        end else begin
          // stray update beat
          enqueue_beat('{OP_UPDATE, rand_index(), rand_value(),
                         1'($urandom_range(1)), 1'($urandom_range(1))});
          if (pending_beats[$].last) unreplayed--;
        end
      end
      wait_drained();
    end
    calm = 1'b0;

    if (mismatches == 0 && expected_scores.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
